@@ rtl/core/rpst_pkg.sv @@
package rpst_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 16;
  localparam int InUserW  = 2;
  localparam int OutDataW = 72;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_ABORT  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    VERDICT_EMPTY  = 2'd0,
    VERDICT_SINGLE = 2'd1,
    VERDICT_MULTI  = 2'd2,
    VERDICT_OTHER  = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_COARSE = 3'd1,
    PH_FINE   = 3'd2,
    PH_VERIFY = 3'd3,
    PH_DONE   = 3'd4,
    PH_FAILED = 3'd5
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POWER_MIN   = 3'd0,
    REG_POWER_MAX   = 3'd1,
    REG_COARSE_STEP = 3'd2,
    REG_FINE_STEP   = 3'd3,
    REG_SAMPLES     = 3'd4,
    REG_MIN_HITS    = 3'd5,
    REG_HEADROOM    = 3'd6
  } reg_idx_t;

  localparam logic [3:0] NOTE_NONE          = 4'd0;
  localparam logic [3:0] NOTE_START_FAIL    = 4'd1;
  localparam logic [3:0] NOTE_COARSE_START  = 4'd2;
  localparam logic [3:0] NOTE_COARSE_COLL   = 4'd3;
  localparam logic [3:0] NOTE_FINE_COLL     = 4'd4;
  localparam logic [3:0] NOTE_COLL_AT_MIN   = 4'd5;
  localparam logic [3:0] NOTE_SEARCH_EDGE   = 4'd6;
  localparam logic [3:0] NOTE_NO_TAG        = 4'd7;
  localparam logic [3:0] NOTE_EMPTY_FIELD   = 4'd8;
  localparam logic [3:0] NOTE_UNSTABLE      = 4'd9;
  localparam logic [3:0] NOTE_VERIFYING     = 4'd10;
  localparam logic [3:0] NOTE_DONE          = 4'd11;
  localparam logic [3:0] NOTE_VERIFY_DOWN   = 4'd12;
  localparam logic [3:0] NOTE_VERIFY_UP     = 4'd13;
  localparam logic [3:0] NOTE_NO_WINDOW     = 4'd14;
  localparam logic [3:0] NOTE_ABORTED       = 4'd15;

  typedef struct packed {
    logic [6:0] power_min;
    logic [6:0] power_max;
    logic [6:0] coarse_step;
    logic [6:0] fine_step;
    logic [7:0] samples_per_step;
    logic [7:0] min_stable_hits;
    logic [6:0] headroom;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] power;
    logic [6:0] ceiling;
    logic [6:0] low_edge;
    logic [6:0] result;
    logic [7:0] samples;
    logic [7:0] singles;
    logic [7:0] multis;
    logic [7:0] empties;
    logic [3:0] note;
  } sweep_state_t;

endpackage

@@ rtl/core/rpst_cfg.sv @@
module rpst_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rpst_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [rpst_pkg::CfgDataW-1:0]   cfg_data,
  output rpst_pkg::cfg_t                  cfg
);
  import rpst_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_min        <= 7'd10;
      cfg.power_max        <= 7'd100;
      cfg.coarse_step      <= 7'd10;
      cfg.fine_step        <= 7'd2;
      cfg.samples_per_step <= 8'd8;
      cfg.min_stable_hits  <= 8'd6;
      cfg.headroom         <= 7'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWER_MIN:   cfg.power_min        <= cfg_data[6:0];
        REG_POWER_MAX:   cfg.power_max        <= cfg_data[6:0];
        REG_COARSE_STEP: cfg.coarse_step      <= cfg_data[6:0];
        REG_FINE_STEP:   cfg.fine_step        <= cfg_data[6:0];
        REG_SAMPLES:     cfg.samples_per_step <= cfg_data;
        REG_MIN_HITS:    cfg.min_stable_hits  <= cfg_data;
        REG_HEADROOM:    cfg.headroom         <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/rpst_next.sv @@
module rpst_next (
  input  rpst_pkg::cfg_t          cfg,
  input  rpst_pkg::sweep_state_t  cur,
  input  logic [1:0]              func,
  input  logic [1:0]              verdict,
  input  logic [6:0]              start_pct,
  input  logic                    field_ready,
  output rpst_pkg::sweep_state_t  nxt,
  output logic                    applied
);
  import rpst_pkg::*;

  logic signed [8:0] req;
  logic signed [8:0] req_lo;
  logic [6:0]        clamped;
  logic              do_enter;
  logic              set_result;
  phase_t            enter_ph;
  logic [3:0]        enter_note;
  logic [7:0]        samples_inc;
  logic [7:0]        singles_inc;
  logic [7:0]        multis_inc;
  logic [7:0]        empties_inc;
  logic              is_multi;
  logic              is_single;
  logic              stable;
  logic              sweeping;
  logic [6:0]        step;
  logic [7:0]        min_plus_step;
  logic [7:0]        min_plus_coarse;
  logic [7:0]        cand_head;
  logic [8:0]        mid_sum;
  logic signed [8:0] cur_s;
  logic signed [8:0] fs_s;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // requests span below zero and above the 7-bit range; clamp min first, max wins
  always_comb begin
    req_lo = (req < $signed({2'b00, cfg.power_min})) ? $signed({2'b00, cfg.power_min}) : req;
    if (req_lo > $signed({2'b00, cfg.power_max})) begin
      clamped = cfg.power_max;
    end else begin
      clamped = req_lo[6:0];
    end
  end

  always_comb begin
    is_multi  = (verdict == VERDICT_MULTI);
    is_single = (verdict == VERDICT_SINGLE);
    sweeping  = (cur.phase == PH_COARSE) || (cur.phase == PH_FINE) || (cur.phase == PH_VERIFY);
    samples_inc = sat_inc(cur.samples);
    singles_inc = is_single ? sat_inc(cur.singles) : cur.singles;
    multis_inc  = is_multi ? sat_inc(cur.multis) : cur.multis;
    empties_inc = (!is_single && !is_multi) ? sat_inc(cur.empties) : cur.empties;
    stable = (singles_inc >= cfg.min_stable_hits);
    step = (cur.phase == PH_COARSE) ? cfg.coarse_step : cfg.fine_step;
    min_plus_step   = {1'b0, cfg.power_min} + {1'b0, step};
    min_plus_coarse = {1'b0, cfg.power_min} + {1'b0, cfg.coarse_step};
    cand_head = {1'b0, cur.low_edge} + {1'b0, cfg.headroom};
    mid_sum   = {2'b00, cur.low_edge} + {2'b00, cur.ceiling} + 9'd1;
    cur_s = $signed({2'b00, cur.power});
    fs_s  = $signed({2'b00, cfg.fine_step});

    nxt        = cur;
    req        = '0;
    do_enter   = 1'b0;
    set_result = 1'b0;
    enter_ph   = cur.phase;
    enter_note = NOTE_NONE;

    unique case (func)
      FUNC_SAMPLE: begin
        if (sweeping) begin
          nxt.samples = samples_inc;
          nxt.singles = singles_inc;
          nxt.multis  = multis_inc;
          nxt.empties = empties_inc;
          if (is_multi && cur.phase != PH_VERIFY) begin
            if ({1'b0, cur.power} <= min_plus_step) begin
              nxt.phase = PH_FAILED;
              nxt.note  = NOTE_COLL_AT_MIN;
            end else begin
              do_enter   = 1'b1;
              req        = cur_s - $signed({2'b00, step});
              enter_note = (cur.phase == PH_COARSE) ? NOTE_COARSE_COLL : NOTE_FINE_COLL;
            end
          end else if (samples_inc >= cfg.samples_per_step) begin
            priority case (cur.phase)
              PH_COARSE: begin
                if (stable) begin
                  nxt.ceiling  = cur.power;
                  nxt.low_edge = cur.power;
                  do_enter     = 1'b1;
                  enter_ph     = PH_FINE;
                  req          = cur_s - fs_s;
                  enter_note   = NOTE_SEARCH_EDGE;
                end else if ({1'b0, cur.power} <= min_plus_coarse) begin
                  nxt.phase = PH_FAILED;
                  nxt.note  = NOTE_NO_TAG;
                end else if (cur.ceiling == 7'd0 && empties_inc == samples_inc &&
                             cur.power < cfg.power_max) begin
                  nxt.phase = PH_FAILED;
                  nxt.note  = NOTE_EMPTY_FIELD;
                end else begin
                  do_enter   = 1'b1;
                  req        = cur_s - $signed({2'b00, cfg.coarse_step});
                  enter_note = NOTE_UNSTABLE;
                end
              end
              PH_FINE: begin
                do_enter = 1'b1;
                if (stable && cur.power > cfg.power_min) begin
                  nxt.low_edge = cur.power;
                  req          = cur_s - fs_s;
                  enter_note   = NOTE_SEARCH_EDGE;
                end else begin
                  enter_ph   = PH_VERIFY;
                  enter_note = NOTE_VERIFYING;
                  set_result = 1'b1;
                  if (cur.ceiling != 7'd0 && cand_head > {1'b0, cur.ceiling}) begin
                    req = $signed({1'b0, mid_sum[8:1]});
                  end else begin
                    req = $signed({1'b0, cand_head});
                  end
                end
              end
              default: begin
                if (stable && multis_inc == 8'd0) begin
                  nxt.result = cur.power;
                  nxt.phase  = PH_DONE;
                  nxt.note   = NOTE_DONE;
                end else if (multis_inc != 8'd0 && cur.power > cfg.power_min) begin
                  do_enter   = 1'b1;
                  req        = cur_s - fs_s;
                  enter_note = NOTE_VERIFY_DOWN;
                end else if (cur.power < cur.ceiling) begin
                  do_enter   = 1'b1;
                  req        = cur_s + fs_s;
                  enter_note = NOTE_VERIFY_UP;
                end else begin
                  nxt.phase = PH_FAILED;
                  nxt.note  = NOTE_NO_WINDOW;
                end
              end
            endcase
          end
        end
      end
      FUNC_START: begin
        if (!field_ready) begin
          nxt.phase = PH_FAILED;
          nxt.note  = NOTE_START_FAIL;
        end else begin
          nxt.ceiling  = '0;
          nxt.low_edge = '0;
          nxt.result   = '0;
          do_enter     = 1'b1;
          enter_ph     = PH_COARSE;
          enter_note   = NOTE_COARSE_START;
          req = $signed({2'b00, (start_pct != 7'd0) ? start_pct : cfg.power_max});
        end
      end
      FUNC_ABORT: begin
        nxt.phase = PH_IDLE;
        nxt.note  = NOTE_ABORTED;
      end
      default: ;
    endcase

    applied = do_enter;
    if (do_enter) begin
      nxt.phase   = enter_ph;
      nxt.note    = enter_note;
      nxt.samples = '0;
      nxt.singles = '0;
      nxt.multis  = '0;
      nxt.empties = '0;
      nxt.power   = clamped;
      if (set_result) begin
        nxt.result = clamped;
      end
    end
  end

endmodule

@@ rtl/core/rf_power_sweep_tuner_unit.sv @@
// channel   dir  payload (low bit first)
// s_*       in   tdata: verdict[1:0] start_pct[8:2] field_ready[9]; tuser: func[1:0]
// m_*       out  tdata: power_pct, phase, status_note, result_pct, sample/single/
//                multi/empty counts, ceiling_pct, low_edge_pct, power_applied
// cfg_*     in   write enable, register index, data
//
// One event per cycle unless stalled; its result is valid in the cycle after.
// The sweep state and the result register update in the same edge.
// s_tready is high while the result register is empty or being taken.
// Synchronous reset restores register defaults and an idle sweep.
module rf_power_sweep_tuner_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // verdict[1:0], start_pct[8:2], field_ready[9], zero[15:10]
  input  logic [rpst_pkg::InDataW-1:0]        s_tdata,
  // func[1:0]
  input  logic [rpst_pkg::InUserW-1:0]        s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // power_pct[6:0], phase[9:7], status_note[13:10], result_pct[20:14],
  // sample_count[28:21], single_count[36:29], multi_count[44:37],
  // empty_count[52:45], ceiling_pct[59:53], low_edge_pct[66:60],
  // power_applied[67], zero[71:68]
  output logic [rpst_pkg::OutDataW-1:0]       m_tdata,
  input  logic                                cfg_we,
  input  logic [rpst_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [rpst_pkg::CfgDataW-1:0]       cfg_data
);
  import rpst_pkg::*;

  cfg_t         cfg;
  sweep_state_t state;
  sweep_state_t state_next;
  logic         applied;
  logic         xfer;

  rpst_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpst_next u_next (
    .cfg         (cfg),
    .cur         (state),
    .func        (s_tuser),
    .verdict     (s_tdata[1:0]),
    .start_pct   (s_tdata[8:2]),
    .field_ready (s_tdata[9]),
    .nxt         (state_next),
    .applied     (applied)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign xfer     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (xfer) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      m_tdata <= {4'b0000, applied, state_next.low_edge, state_next.ceiling,
                  state_next.empties, state_next.multis, state_next.singles,
                  state_next.samples, state_next.result, state_next.note,
                  state_next.phase, state_next.power};
    end
  end

endmodule

@@ rtl/core/rpst_chk.sv @@
module rpst_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rpst_pkg::OutDataW-1:0]   m_tdata
);
  import rpst_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted event produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_applied_sweeping: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[67]) |->
      (m_tdata[9:7] == PH_COARSE || m_tdata[9:7] == PH_FINE || m_tdata[9:7] == PH_VERIFY))
    else $error("power applied outside a sweep phase");

endmodule

bind rf_power_sweep_tuner_unit rpst_chk u_rpst_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rpst_pkg::*;

  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    func_t      func;
    verdict_t   verdict;
    logic [6:0] pct;
    logic       ready;
  } cmd_t;

  typedef struct packed {
    logic [6:0] power;
    phase_t     phase;
    logic [3:0] note;
    logic [6:0] result;
    logic [7:0] samples;
    logic [7:0] singles;
    logic [7:0] multis;
    logic [7:0] empties;
    logic [6:0] ceiling;
    logic [6:0] low_edge;
    logic       applied;
  } reading_t;

  typedef struct {
    cmd_t     cmd;
    bit       typed;
    reading_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // verdict, start_pct, field_ready, zero pad
  logic [InDataW-1:0] s_tdata = '0;
  // func
  logic [InUserW-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // power, phase, note, result, four counts, ceiling, low edge, applied
  logic [OutDataW-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  cfg_t         regs;
  sweep_state_t st;
  logic         applied;
  reading_t     pending_readings[$];
  plan_row_t    plan[$];

  int mismatches = 0;
  int readings_seen = 0;
  int stall_cycles = 0;
  int rx_mode = 0;
  bit gaps_on = 1'b1;
  int burst_left = 1;
  int win_lo = 0;
  int win_hi = 100;
  logic [7:0] rx_tick = '0;

  rf_power_sweep_tuner_unit dut (.*);

  always #5 clk = ~clk;

  // ---------------- sweep predictor ----------------

  function automatic logic [6:0] clamp_level(int req);
    int lvl;
    lvl = req;
    if (lvl < int'(regs.power_min)) lvl = int'(regs.power_min);
    if (lvl > int'(regs.power_max)) lvl = int'(regs.power_max);
    return lvl[6:0];
  endfunction

  function automatic logic [7:0] bump(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  task automatic enter_level(phase_t ph, int req, logic [3:0] note);
    st.phase = ph;
    st.note = note;
    st.samples = '0;
    st.singles = '0;
    st.multis = '0;
    st.empties = '0;
    st.power = clamp_level(req);
    applied = 1'b1;
  endtask

  task automatic conclude(phase_t ph, logic [3:0] note);
    st.phase = ph;
    st.note = note;
  endtask

  task automatic judge_sample(verdict_t v);
    int cur, pmin, fs, step, cand;
    bit stable, coarse;
    if (st.phase != PH_COARSE && st.phase != PH_FINE && st.phase != PH_VERIFY) return;
    cur = int'(st.power);
    pmin = int'(regs.power_min);
    fs = int'(regs.fine_step);
    st.samples = bump(st.samples);
    if (v == VERDICT_MULTI) st.multis = bump(st.multis);
    else if (v == VERDICT_SINGLE) st.singles = bump(st.singles);
    else st.empties = bump(st.empties);

    // collision outside verify backs off right away, or fails within one step of the minimum
    if (v == VERDICT_MULTI && st.phase != PH_VERIFY) begin
      coarse = (st.phase == PH_COARSE);
      step = coarse ? int'(regs.coarse_step) : fs;
      if (cur <= pmin + step) conclude(PH_FAILED, NOTE_COLL_AT_MIN);
      else enter_level(st.phase, cur - step, coarse ? NOTE_COARSE_COLL : NOTE_FINE_COLL);
      return;
    end

    if (st.samples < regs.samples_per_step) return;
    stable = (st.singles >= regs.min_stable_hits);

    case (st.phase)
      PH_COARSE: begin
        if (stable) begin
          st.ceiling = st.power;
          st.low_edge = st.power;
          enter_level(PH_FINE, cur - fs, NOTE_SEARCH_EDGE);
        end else if (cur <= pmin + int'(regs.coarse_step)) begin
          conclude(PH_FAILED, NOTE_NO_TAG);
        end else if (st.ceiling == 0 && st.empties == st.samples &&
                     st.power < regs.power_max) begin
          conclude(PH_FAILED, NOTE_EMPTY_FIELD);
        end else begin
          enter_level(PH_COARSE, cur - int'(regs.coarse_step), NOTE_UNSTABLE);
        end
      end
      PH_FINE: begin
        if (stable && cur > pmin) begin
          st.low_edge = st.power;
          enter_level(PH_FINE, cur - fs, NOTE_SEARCH_EDGE);
        end else begin
          cand = int'(st.low_edge) + int'(regs.headroom);
          if (st.ceiling > 0 && cand > int'(st.ceiling))
            cand = (int'(st.low_edge) + int'(st.ceiling) + 1) / 2;
          enter_level(PH_VERIFY, cand, NOTE_VERIFYING);
          st.result = st.power;
        end
      end
      default: begin
        if (stable && st.multis == 0) begin
          st.result = st.power;
          conclude(PH_DONE, NOTE_DONE);
        end else if (st.multis > 0 && cur > pmin) begin
          enter_level(PH_VERIFY, cur - fs, NOTE_VERIFY_DOWN);
        end else if (st.power < st.ceiling) begin
          enter_level(PH_VERIFY, cur + fs, NOTE_VERIFY_UP);
        end else begin
          conclude(PH_FAILED, NOTE_NO_WINDOW);
        end
      end
    endcase
  endtask

  task automatic predict(cmd_t c, output reading_t r);
    applied = 1'b0;
    case (c.func)
      FUNC_SAMPLE: judge_sample(c.verdict);
      FUNC_START: begin
        if (!c.ready) begin
          conclude(PH_FAILED, NOTE_START_FAIL);
        end else begin
          st.ceiling = '0;
          st.low_edge = '0;
          st.result = '0;
          enter_level(PH_COARSE, (c.pct != 0) ? int'(c.pct) : int'(regs.power_max),
                      NOTE_COARSE_START);
        end
      end
      FUNC_ABORT: conclude(PH_IDLE, NOTE_ABORTED);
      default: ;
    endcase
    r.power = st.power;
    r.phase = st.phase;
    r.note = st.note;
    r.result = st.result;
    r.samples = st.samples;
    r.singles = st.singles;
    r.multis = st.multis;
    r.empties = st.empties;
    r.ceiling = st.ceiling;
    r.low_edge = st.low_edge;
    r.applied = applied;
  endtask

  // ---------------- checking ----------------

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 50) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0d, want %0d", readings_seen, name, got, want));
  endtask

  function automatic reading_t unpack_reading(logic [OutDataW-1:0] d);
    reading_t r;
    r.power = d[6:0];
    r.phase = phase_t'(d[9:7]);
    r.note = d[13:10];
    r.result = d[20:14];
    r.samples = d[28:21];
    r.singles = d[36:29];
    r.multis = d[44:37];
    r.empties = d[52:45];
    r.ceiling = d[59:53];
    r.low_edge = d[66:60];
    r.applied = d[67];
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    reading_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      readings_seen++;
      got = unpack_reading(m_tdata);
      if (pending_readings.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", readings_seen));
      end else begin
        want = pending_readings.pop_front();
        compare_field("power_pct", 8'(got.power), 8'(want.power));
        compare_field("phase", 8'(got.phase), 8'(want.phase));
        compare_field("status_note", 8'(got.note), 8'(want.note));
        compare_field("result_pct", 8'(got.result), 8'(want.result));
        compare_field("sample_count", got.samples, want.samples);
        compare_field("single_count", got.singles, want.singles);
        compare_field("multi_count", got.multis, want.multis);
        compare_field("empty_count", got.empties, want.empties);
        compare_field("ceiling_pct", 8'(got.ceiling), 8'(want.ceiling));
        compare_field("low_edge_pct", 8'(got.low_edge), 8'(want.low_edge));
        compare_field("power_applied", 8'(got.applied), 8'(want.applied));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 6);
      2: m_tready <= (rx_tick[2:0] != 3'd2) && (rx_tick[2:0] != 3'd5);
      default: m_tready <= (rx_tick[5:3] != 3'd6);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_item(cmd_t c, bit typed, reading_t want);
    reading_t pred;
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, c.ready, c.pct, c.verdict};
    s_tuser <= c.func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(c, pred);
    pending_readings.push_back(typed ? want : pred);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic add_row(func_t f, verdict_t v, int pct, bit rdy, bit typed,
                         int power, phase_t ph, logic [3:0] note, bit appl);
    plan_row_t row;
    row.cmd.func = f;
    row.cmd.verdict = v;
    row.cmd.pct = pct[6:0];
    row.cmd.ready = rdy;
    row.typed = typed;
    row.want = '0;
    row.want.power = power[6:0];
    row.want.phase = ph;
    row.want.note = note;
    row.want.applied = appl;
    plan.push_back(row);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    logic [7:0] data;
    data = value[7:0];
    if (idx != REG_SAMPLES && idx != REG_MIN_HITS) data[7] = 1'($urandom_range(0, 1));
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_POWER_MIN:   regs.power_min = data[6:0];
      REG_POWER_MAX:   regs.power_max = data[6:0];
      REG_COARSE_STEP: regs.coarse_step = data[6:0];
      REG_FINE_STEP:   regs.fine_step = data[6:0];
      REG_SAMPLES:     regs.samples_per_step = data;
      REG_MIN_HITS:    regs.min_stable_hits = data;
      REG_HEADROOM:    regs.headroom = data[6:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(int pmin, int pmax, int cstep, int fstep,
                                int spp, int hits, int head);
    wait_quiet();
    write_reg(REG_POWER_MIN, pmin);
    write_reg(REG_POWER_MAX, pmax);
    write_reg(REG_COARSE_STEP, cstep);
    write_reg(REG_FINE_STEP, fstep);
    write_reg(REG_SAMPLES, spp);
    write_reg(REG_MIN_HITS, hits);
    write_reg(REG_HEADROOM, head);
    cfg_we <= 1'b0;
  endtask

  // tag model: multi or single above the window, mostly single inside, mostly empty below
  function automatic verdict_t pick_verdict();
    int r, p;
    r = $urandom_range(0, 99);
    p = int'(st.power);
    if (r < 4) return verdict_t'($urandom_range(0, 3));
    if (p > win_hi) return (r < 55) ? VERDICT_MULTI : VERDICT_SINGLE;
    if (p >= win_lo) return (r < 90) ? VERDICT_SINGLE : VERDICT_EMPTY;
    return (r < 15) ? VERDICT_SINGLE : VERDICT_EMPTY;
  endfunction

  function automatic bit sweeping();
    return st.phase == PH_COARSE || st.phase == PH_FINE || st.phase == PH_VERIFY;
  endfunction

  function automatic cmd_t any_cmd();
    cmd_t c;
    c.func = func_t'($urandom_range(0, 3));
    c.verdict = verdict_t'($urandom_range(0, 3));
    c.pct = 7'($urandom_range(0, 127));
    c.ready = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic random_sweeps(int budget);
    cmd_t c;
    int useful, steps, r;
    useful = 0;
    while (useful < budget) begin
      win_lo = $urandom_range(0, 80);
      win_hi = win_lo + $urandom_range(0, 40);
      c = any_cmd();
      c.func = FUNC_START;
      c.ready = ($urandom_range(0, 19) != 0);
      r = $urandom_range(0, 9);
      if (r == 0) c.pct = '0;
      else if (r > 2) c.pct = 7'($urandom_range(20, 100));
      send_item(c, 1'b0, '0);
      useful++;
      steps = 0;
      while (sweeping() && useful < budget && steps < 300) begin
        r = $urandom_range(0, 99);
        c = any_cmd();
        if (r < 2) begin
          c.func = FUNC_ABORT;
        end else if (r < 4) begin
          c.func = FUNC_START;
        end else if (r >= 7) begin
          c.func = FUNC_SAMPLE;
          c.verdict = pick_verdict();
        end
        if (c.func != FUNC_NONE) useful++;
        send_item(c, 1'b0, '0);
        steps++;
      end
      repeat ($urandom_range(0, 2)) send_item(any_cmd(), 1'b0, '0);
    end
  endtask

  initial begin
    int spp;
    regs.power_min = 7'd10;
    regs.power_max = 7'd100;
    regs.coarse_step = 7'd10;
    regs.fine_step = 7'd2;
    regs.samples_per_step = 8'd8;
    regs.min_stable_hits = 8'd6;
    regs.headroom = 7'd5;
    st = '0;
    st.phase = PH_IDLE;
    applied = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: reset values, ignored events, start limits, first collisions
    add_row(FUNC_ABORT, VERDICT_EMPTY, 0, 1, 1, 0, PH_IDLE, NOTE_ABORTED, 0);
    add_row(FUNC_SAMPLE, VERDICT_SINGLE, 0, 1, 1, 0, PH_IDLE, NOTE_ABORTED, 0);
    add_row(FUNC_START, VERDICT_EMPTY, 50, 0, 1, 0, PH_FAILED, NOTE_START_FAIL, 0);
    add_row(FUNC_NONE, VERDICT_MULTI, 127, 1, 1, 0, PH_FAILED, NOTE_START_FAIL, 0);
    add_row(FUNC_START, VERDICT_EMPTY, 0, 1, 1, 100, PH_COARSE, NOTE_COARSE_START, 1);
    add_row(FUNC_START, VERDICT_OTHER, 127, 1, 1, 100, PH_COARSE, NOTE_COARSE_START, 1);
    add_row(FUNC_START, VERDICT_EMPTY, 1, 1, 1, 10, PH_COARSE, NOTE_COARSE_START, 1);
    add_row(FUNC_START, VERDICT_EMPTY, 100, 1, 1, 100, PH_COARSE, NOTE_COARSE_START, 1);
    add_row(FUNC_SAMPLE, VERDICT_MULTI, 0, 0, 1, 90, PH_COARSE, NOTE_COARSE_COLL, 1);
    repeat (7) add_row(FUNC_SAMPLE, VERDICT_SINGLE, 0, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    add_row(FUNC_SAMPLE, VERDICT_OTHER, 0, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    add_row(FUNC_SAMPLE, VERDICT_MULTI, 0, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    add_row(FUNC_SAMPLE, VERDICT_SINGLE, 0, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    add_row(FUNC_ABORT, VERDICT_EMPTY, 0, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    add_row(FUNC_SAMPLE, VERDICT_EMPTY, 0, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    add_row(FUNC_START, VERDICT_EMPTY, 15, 1, 1, 15, PH_COARSE, NOTE_COARSE_START, 1);
    add_row(FUNC_SAMPLE, VERDICT_MULTI, 0, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    add_row(FUNC_START, VERDICT_SINGLE, 127, 0, 0, 0, PH_IDLE, NOTE_NONE, 0);
    foreach (plan[k]) send_item(plan[k].cmd, plan[k].typed, plan[k].want);

    for (int ph = 0; ph < 10; ph++) begin
      spp = $urandom_range(1, 12);
      case (ph)
        0: write_settings(10, 100, 10, 2, 8, 6, 5);
        1: write_settings(0, 100, 1, 1, 1, 1, 0);
        2: write_settings(100, 100, 100, 100, 255, 255, 100);
        3: write_settings(60, 40, 7, 3, 4, 3, 20);
        4: write_settings(0, 127, 0, 0, 0, 0, 127);
        9: write_settings($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 127));
        default: write_settings($urandom_range(0, 40), $urandom_range(40, 100),
                                $urandom_range(1, 30), $urandom_range(1, 10),
                                spp, $urandom_range(1, spp), $urandom_range(0, 30));
      endcase
      rx_mode = (ph < 5) ? ph % 4 : $urandom_range(0, 3);
      gaps_on = (ph % 3 != 1);
      random_sweeps(60);
    end

    wait_quiet();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
